### hdl/cts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cts_pkg;
    localparam int COORD_BITS = 16;
    localparam int FORCE_BITS = 16;
    localparam int COUNT_BITS = 32;
    localparam int SUM_BITS = FORCE_BITS + COUNT_BITS;
    localparam int LEN_BITS = 32;
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int SQ_BITS = 2 * DIFF_BITS + 1;
    localparam int ROOT_BITS = DIFF_BITS + 1;
    localparam int RATIO_BITS = 17;

    typedef struct packed {
        logic                         pen_down;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic [FORCE_BITS-1:0]        force_req;
        logic                         last;
    } t_in;

    typedef struct packed {
        logic [COUNT_BITS-1:0]        segment_count;
        logic [LEN_BITS-1:0]          drawn_length;
        logic [FORCE_BITS-1:0]        force_min;
        logic [FORCE_BITS-1:0]        force_max;
        logic [FORCE_BITS-1:0]        force_mean;
        logic                         force_valid;
        logic [RATIO_BITS-1:0]        duty_ratio;
        logic signed [COORD_BITS-1:0] box_min_x;
        logic signed [COORD_BITS-1:0] box_min_y;
        logic signed [COORD_BITS-1:0] box_max_x;
        logic signed [COORD_BITS-1:0] box_max_y;
        logic                         box_valid;
    } t_out;

    // Classified sample handed from the front part to the back part.
    typedef struct packed {
        logic                         touch;
        logic                         new_seg;
        logic                         add_len;
        logic [DIFF_BITS-1:0]         dx;
        logic [DIFF_BITS-1:0]         dy;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [FORCE_BITS-1:0]        frc;
        logic                         last;
    } t_work;
endpackage
`default_nettype wire

### hdl/cts_front.sv
`timescale 1ns / 1ps
`default_nettype none
module cts_front import cts_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    output logic       o_full,
    input  wire t_in   i_item,
    output logic       o_valid,
    output t_work      o_work,
    input  wire logic  i_ready
);
    logic                         r_prev_touch;
    logic signed [COORD_BITS-1:0] r_prev_x, r_prev_y;
    logic                         r_valid;
    t_work                        r_work;
    logic signed [DIFF_BITS-1:0]  w_dx, w_dy;

    assign o_full  = r_valid && !i_ready;
    assign o_valid = r_valid;
    assign o_work  = r_work;

    assign w_dx = DIFF_BITS'(i_item.pos_x) - DIFF_BITS'(r_prev_x);
    assign w_dy = DIFF_BITS'(i_item.pos_y) - DIFF_BITS'(r_prev_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_touch <= 1'b0;
            r_prev_x     <= '0;
            r_prev_y     <= '0;
            r_valid      <= 1'b0;
        end else begin
            if (i_ready) r_valid <= 1'b0;
            if (i_push && !o_full) begin
                r_valid         <= 1'b1;
                r_work.touch    <= i_item.pen_down;
                r_work.new_seg  <= i_item.pen_down && !r_prev_touch;
                r_work.add_len  <= i_item.pen_down && r_prev_touch;
                r_work.dx       <= w_dx[DIFF_BITS-1] ? DIFF_BITS'(-w_dx) : DIFF_BITS'(w_dx);
                r_work.dy       <= w_dy[DIFF_BITS-1] ? DIFF_BITS'(-w_dy) : DIFF_BITS'(w_dy);
                r_work.x        <= i_item.pos_x;
                r_work.y        <= i_item.pos_y;
                r_work.frc      <= i_item.force_req;
                r_work.last     <= i_item.last;
                r_prev_touch    <= i_item.last ? 1'b0 : i_item.pen_down;
                r_prev_x        <= i_item.last ? '0 : i_item.pos_x;
                r_prev_y        <= i_item.last ? '0 : i_item.pos_y;
            end
        end
    end
endmodule
`default_nettype wire

### hdl/cts_back.sv
`timescale 1ns / 1ps
`default_nettype none
module cts_back import cts_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_work i_work,
    output logic       o_ready,
    output logic       o_empty,
    input  wire logic  i_pop,
    output t_out       o_res
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_ROOT = 3'd2;
    localparam logic [2:0] ST_MEAN = 3'd3;
    localparam logic [2:0] ST_DUTY = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;
    localparam int RB = $clog2(ROOT_BITS + 1);
    localparam int MB = $clog2(SUM_BITS + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;
    localparam logic [LEN_BITS-1:0] LMAX = '1;
    localparam logic [SUM_BITS-1:0] SMAX = '1;

    logic [2:0]                   r_st;
    t_work                        r_w;
    logic [COUNT_BITS-1:0]        r_seg, r_tc, r_st_tot;
    logic [LEN_BITS-1:0]          r_len;
    logic [FORCE_BITS-1:0]        r_flo, r_fhi;
    logic [SUM_BITS-1:0]          r_sum;
    logic signed [COORD_BITS-1:0] r_bxl, r_byl, r_bxh, r_byh;
    logic [SQ_BITS-1:0]           r_sq;
    logic [ROOT_BITS-1:0]         r_root;
    logic [RB-1:0]                r_bit;
    logic [MB-1:0]                r_cnt;
    logic [SUM_BITS-1:0]          r_q;
    logic [COUNT_BITS:0]          r_rem;
    logic                         r_full;
    t_out                         r_res;

    logic [ROOT_BITS-1:0]   w_try;
    logic [2*ROOT_BITS-1:0] w_tsq;
    logic [COUNT_BITS:0]    w_rsh;
    logic [COUNT_BITS:0]    w_dsh;
    logic [LEN_BITS:0]      w_lsum;
    logic [SUM_BITS:0]      w_fsum;
    logic [SUM_BITS-1:0]    w_fsat;
    logic [2*DIFF_BITS-1:0] w_dx2, w_dy2;

    assign o_ready = (r_st == ST_IDLE);
    assign o_empty = !r_full;
    assign o_res   = r_res;

    assign w_try  = r_root | (ROOT_BITS'(1) << r_bit);
    assign w_tsq  = w_try * w_try;
    assign w_rsh  = {r_rem[COUNT_BITS-1:0], r_q[SUM_BITS-1]};
    assign w_dsh  = {r_rem[COUNT_BITS-1:0], 1'b0};
    assign w_lsum = {1'b0, r_len} + (LEN_BITS+1)'(r_root);
    assign w_fsum = {1'b0, r_sum} + (SUM_BITS+1)'(r_w.frc);
    assign w_fsat = w_fsum[SUM_BITS] ? SMAX : w_fsum[SUM_BITS-1:0];
    assign w_dx2  = (2*DIFF_BITS)'(r_w.dx) * (2*DIFF_BITS)'(r_w.dx);
    assign w_dy2  = (2*DIFF_BITS)'(r_w.dy) * (2*DIFF_BITS)'(r_w.dy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_full   <= 1'b0;
            r_seg    <= '0;
            r_tc     <= '0;
            r_st_tot <= '0;
            r_len    <= '0;
            r_sum    <= '0;
            r_flo    <= '0;
            r_fhi    <= '0;
            r_bxl    <= '0;
            r_byl    <= '0;
            r_bxh    <= '0;
            r_byh    <= '0;
        end else begin
            if (i_pop && r_full) r_full <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_w      <= i_work;
                        r_st_tot <= (r_st_tot == CMAX) ? CMAX : r_st_tot + 1'b1;
                        if (i_work.touch) begin
                            if (i_work.new_seg)
                                r_seg <= (r_seg == CMAX) ? CMAX : r_seg + 1'b1;
                            if (r_tc == '0) begin
                                r_flo <= i_work.frc;
                                r_fhi <= i_work.frc;
                                r_bxl <= i_work.x;
                                r_bxh <= i_work.x;
                                r_byl <= i_work.y;
                                r_byh <= i_work.y;
                            end else begin
                                if (i_work.frc < r_flo) r_flo <= i_work.frc;
                                if (i_work.frc > r_fhi) r_fhi <= i_work.frc;
                                if (i_work.x < r_bxl) r_bxl <= i_work.x;
                                if (i_work.x > r_bxh) r_bxh <= i_work.x;
                                if (i_work.y < r_byl) r_byl <= i_work.y;
                                if (i_work.y > r_byh) r_byh <= i_work.y;
                            end
                            r_tc <= (r_tc == CMAX) ? CMAX : r_tc + 1'b1;
                        end
                        r_st <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    if (r_w.touch)
                        r_sum <= w_fsat;
                    r_sq   <= SQ_BITS'(w_dx2) + SQ_BITS'(w_dy2);
                    r_root <= '0;
                    r_bit  <= RB'(ROOT_BITS - 1);
                    r_st   <= r_w.add_len ? ST_ROOT : (r_w.last ? ST_MEAN : ST_IDLE);
                    r_q    <= r_w.touch ? w_fsat : r_sum;
                    r_rem  <= '0;
                    r_cnt  <= '0;
                end
                ST_ROOT: begin
                    // One result bit per cycle, most significant first.
                    if ((2*ROOT_BITS)'(r_sq) >= w_tsq) r_root <= w_try;
                    if (r_bit == '0) begin
                        r_st <= ST_OUT;
                    end else begin
                        r_bit <= r_bit - 1'b1;
                    end
                end
                ST_OUT: begin
                    r_len <= w_lsum[LEN_BITS] ? LMAX : w_lsum[LEN_BITS-1:0];
                    r_q   <= r_sum;
                    r_st  <= r_w.last ? ST_MEAN : ST_IDLE;
                end
                ST_MEAN: begin
                    // Restoring division of the force sum by the touch count.
                    if (r_full) begin
                        r_st <= ST_MEAN;
                    end else if (r_cnt == MB'(SUM_BITS)) begin
                        r_res.force_mean <= (r_tc == '0) ? '0 :
                            ((|r_q[SUM_BITS-1:FORCE_BITS]) ? '1 : r_q[FORCE_BITS-1:0]);
                        r_q   <= '0;
                        r_rem <= {1'b0, r_tc};
                        r_cnt <= '0;
                        r_st  <= ST_DUTY;
                    end else begin
                        if (w_rsh >= {1'b0, r_tc}) begin
                            r_rem <= w_rsh - {1'b0, r_tc};
                            r_q   <= {r_q[SUM_BITS-2:0], 1'b1};
                        end else begin
                            r_rem <= w_rsh;
                            r_q   <= {r_q[SUM_BITS-2:0], 1'b0};
                        end
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_DUTY: begin
                    if (r_cnt == MB'(RATIO_BITS)) begin
                        r_res.segment_count <= r_seg;
                        r_res.drawn_length  <= r_len;
                        r_res.force_valid   <= r_tc != '0;
                        r_res.box_valid     <= r_tc != '0;
                        r_res.force_min     <= (r_tc != '0) ? r_flo : '0;
                        r_res.force_max     <= (r_tc != '0) ? r_fhi : '0;
                        r_res.box_min_x     <= (r_tc != '0) ? r_bxl : '0;
                        r_res.box_min_y     <= (r_tc != '0) ? r_byl : '0;
                        r_res.box_max_x     <= (r_tc != '0) ? r_bxh : '0;
                        r_res.box_max_y     <= (r_tc != '0) ? r_byh : '0;
                        r_res.duty_ratio    <= r_q[RATIO_BITS-1:0];
                        r_full   <= 1'b1;
                        r_seg    <= '0;
                        r_tc     <= '0;
                        r_st_tot <= '0;
                        r_len    <= '0;
                        r_sum    <= '0;
                        r_flo    <= '0;
                        r_fhi    <= '0;
                        r_bxl    <= '0;
                        r_byl    <= '0;
                        r_bxh    <= '0;
                        r_byh    <= '0;
                        r_st     <= ST_IDLE;
                    end else begin
                        if (r_cnt == '0) begin
                            if (r_rem >= {1'b0, r_st_tot}) begin
                                r_rem <= r_rem - {1'b0, r_st_tot};
                                r_q   <= SUM_BITS'(1);
                            end
                        end else if (w_dsh >= {1'b0, r_st_tot}) begin
                            r_rem <= w_dsh - {1'b0, r_st_tot};
                            r_q   <= {r_q[SUM_BITS-2:0], 1'b1};
                        end else begin
                            r_rem <= w_dsh;
                            r_q   <= {r_q[SUM_BITS-2:0], 1'b0};
                        end
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### hdl/contact_trace_statistics_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Pen trace statistics. A front stage registers each sample, takes the
// absolute coordinate steps and classifies it; the back part updates the
// running statistics and takes a new sample only once done with the last.
// A step length, when needed, comes from a bit-serial square root, one bit
// a cycle. The last sample of a trace runs the mean divider, then the
// duty-ratio divider, queues one result and clears all statistics. The
// mean divider does not start while an earlier result is still unread.
module contact_trace_statistics_core import cts_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    output logic      o_full,
    input  wire t_in  i_item,
    output logic      o_empty,
    input  wire logic i_pop,
    output t_out      o_res
);
    logic  w_valid, w_ready;
    t_work w_work;

    cts_front u_front (
        .i_clk, .i_rst_n, .i_push, .o_full, .i_item,
        .o_valid(w_valid), .o_work(w_work), .i_ready(w_ready)
    );

    cts_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_valid), .i_work(w_work),
        .o_ready(w_ready), .o_empty, .i_pop, .o_res
    );
endmodule
`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import cts_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_push = 1'b0;
    logic i_pop = 1'b0;
    t_in  i_item = '0;
    logic o_full;
    logic o_empty;
    t_out o_res;

    localparam int WATCHDOG_LIMIT = 20000;

    contact_trace_statistics_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .o_full(o_full),
        .i_item(i_item), .o_empty(o_empty), .i_pop(i_pop), .o_res(o_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Running statistics of the trace in progress.
    logic                  trc_prev_touch;
    logic signed [16:0]    trc_prev_x, trc_prev_y;
    logic [31:0]           trc_segments, trc_length, trc_touches, trc_samples;
    logic [15:0]           trc_force_lo, trc_force_hi;
    logic [47:0]           trc_force_sum;
    logic signed [15:0]    trc_lo_x, trc_lo_y, trc_hi_x, trc_hi_y;

    t_in  sample_queue[$];
    t_out summary_queue[$];
    int   errors = 0;
    int   summaries_seen = 0;
    int   samples_sent = 0;
    bit   stim_done = 0;
    bit   hold_off = 0;
    bit   calm = 0;

    function automatic logic [31:0] isqrt(logic [63:0] v);
        logic [31:0] r;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            logic [63:0] t;
            t = {32'd0, r | (32'd1 << b)};
            if (t * t <= v) r = r | (32'd1 << b);
        end
        return r;
    endfunction

    function automatic void clear_trace();
        trc_prev_touch = 0;
        trc_prev_x = 0;
        trc_prev_y = 0;
        trc_segments = 0;
        trc_length = 0;
        trc_touches = 0;
        trc_samples = 0;
        trc_force_lo = 0;
        trc_force_hi = 0;
        trc_force_sum = 0;
        trc_lo_x = 0;
        trc_lo_y = 0;
        trc_hi_x = 0;
        trc_hi_y = 0;
    endfunction

    function automatic void trace_sample(t_in s);
        logic signed [16:0] x, y, dx, dy;
        logic [63:0]        sq, d, mean, q, r;
        t_out               res;
        x = s.pos_x;
        y = s.pos_y;
        if (trc_samples != 32'hFFFF_FFFF) trc_samples++;
        if (s.pen_down) begin
            if (!trc_prev_touch) begin
                if (trc_segments != 32'hFFFF_FFFF) trc_segments++;
            end else begin
                dx = x - trc_prev_x;
                dy = y - trc_prev_y;
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                sq = 64'(dx) * 64'(dx) + 64'(dy) * 64'(dy);
                d = isqrt(sq);
                if (d >= 64'hFFFF_FFFF - trc_length) trc_length = 32'hFFFF_FFFF;
                else trc_length = trc_length + d[31:0];
            end
            if (trc_touches == 0) begin
                trc_force_lo = s.force_req;
                trc_force_hi = s.force_req;
                trc_lo_x = s.pos_x;
                trc_hi_x = s.pos_x;
                trc_lo_y = s.pos_y;
                trc_hi_y = s.pos_y;
            end else begin
                if (s.force_req < trc_force_lo) trc_force_lo = s.force_req;
                if (s.force_req > trc_force_hi) trc_force_hi = s.force_req;
                if (s.pos_x < trc_lo_x) trc_lo_x = s.pos_x;
                if (s.pos_x > trc_hi_x) trc_hi_x = s.pos_x;
                if (s.pos_y < trc_lo_y) trc_lo_y = s.pos_y;
                if (s.pos_y > trc_hi_y) trc_hi_y = s.pos_y;
            end
            trc_force_sum = trc_force_sum + 48'(s.force_req);
            if (trc_touches != 32'hFFFF_FFFF) trc_touches++;
        end
        trc_prev_touch = s.pen_down;
        trc_prev_x = x;
        trc_prev_y = y;
        if (!s.last) return;

        res = '0;
        res.segment_count = trc_segments;
        res.drawn_length = trc_length;
        res.duty_ratio = 17'((64'(trc_touches) << 16) / 64'(trc_samples));
        if (trc_touches != 0) begin
            mean = 64'(trc_force_sum) / 64'(trc_touches);
            res.force_mean = (mean > 64'hFFFF) ? 16'hFFFF : mean[15:0];
            res.force_min = trc_force_lo;
            res.force_max = trc_force_hi;
            res.force_valid = 1'b1;
            res.box_valid = 1'b1;
            res.box_min_x = trc_lo_x;
            res.box_min_y = trc_lo_y;
            res.box_max_x = trc_hi_x;
            res.box_max_y = trc_hi_y;
        end
        summary_queue.push_back(res);
        clear_trace();
    endfunction

    function automatic t_in make_sample(bit touch, int x, int y, int f, bit fin);
        t_in s;
        s.pen_down = touch;
        s.pos_x = 16'(x);
        s.pos_y = 16'(y);
        s.force_req = 16'(f);
        s.last = fin;
        return s;
    endfunction

    // Random trace: mostly pen strokes with small steps, some wild jumps.
    task automatic add_trace(int n);
        int x, y;
        bit touch;
        x = $urandom_range(0, 65535) - 32768;
        y = $urandom_range(0, 65535) - 32768;
        touch = $urandom_range(0, 1);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) touch = !touch;
            if ($urandom_range(0, 7) == 0) begin
                x = $urandom_range(0, 65535) - 32768;
                y = $urandom_range(0, 65535) - 32768;
            end else begin
                x = x + $urandom_range(0, 200) - 100;
                y = y + $urandom_range(0, 200) - 100;
            end
            sample_queue.push_back(make_sample(touch, x, y,
                $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                          : $urandom_range(100, 2000),
                k == n - 1));
        end
    endtask

    initial begin
        // Directed traces: single samples, extremes, no contact, re-touch.
        sample_queue.push_back(make_sample(1, 0, 0, 0, 1));
        sample_queue.push_back(make_sample(0, 5, 5, 9, 1));
        sample_queue.push_back(make_sample(1, -32768, -32768, 65535, 0));
        sample_queue.push_back(make_sample(1, 32767, 32767, 65535, 0));
        sample_queue.push_back(make_sample(1, -32768, 32767, 0, 0));
        sample_queue.push_back(make_sample(1, 32767, -32768, 65535, 1));
        sample_queue.push_back(make_sample(0, 0, 0, 0, 0));
        sample_queue.push_back(make_sample(0, 100, -100, 7, 0));
        sample_queue.push_back(make_sample(0, -1, -1, 65535, 1));
        sample_queue.push_back(make_sample(1, 3, 4, 10, 0));
        sample_queue.push_back(make_sample(1, 0, 0, 20, 0));
        sample_queue.push_back(make_sample(0, 0, 0, 30, 0));
        sample_queue.push_back(make_sample(1, 6, 8, 40, 0));
        sample_queue.push_back(make_sample(1, 6, 8, 1, 0));
        sample_queue.push_back(make_sample(0, 1, 1, 2, 0));
        sample_queue.push_back(make_sample(1, 1, 1, 3, 1));
        while (sample_queue.size() < 1550) add_trace($urandom_range(1, 40));
    end

    // Sender: pops pending samples, idles about 13% except in the calm stretch.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_push && !o_full) begin
                trace_sample(i_item);
                samples_sent++;
            end
            if (!(i_push && o_full)) begin
                if (sample_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 13)) begin
                    i_item <= sample_queue.pop_front();
                    i_push <= 1'b1;
                end else begin
                    i_push <= 1'b0;
                    if (sample_queue.size() == 0) stim_done <= 1'b1;
                end
            end
        end
    end

    // Receiver side of the handshake and field comparison.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_pop && !o_empty) begin
                summaries_seen++;
                if (summary_queue.size() == 0) begin
                    $error("unexpected result beat");
                    errors++;
                end else begin
                    t_out e;
                    e = summary_queue.pop_front();
                    if (o_res.segment_count !== e.segment_count) begin
                        $error("segment_count exp %0d got %0d", e.segment_count,
                               o_res.segment_count); errors++; end
                    if (o_res.drawn_length !== e.drawn_length) begin
                        $error("drawn_length exp %0d got %0d", e.drawn_length,
                               o_res.drawn_length); errors++; end
                    if (o_res.force_min !== e.force_min) begin
                        $error("force_min exp %0d got %0d", e.force_min,
                               o_res.force_min); errors++; end
                    if (o_res.force_max !== e.force_max) begin
                        $error("force_max exp %0d got %0d", e.force_max,
                               o_res.force_max); errors++; end
                    if (o_res.force_mean !== e.force_mean) begin
                        $error("force_mean exp %0d got %0d", e.force_mean,
                               o_res.force_mean); errors++; end
                    if (o_res.force_valid !== e.force_valid) begin
                        $error("force_valid exp %0d got %0d", e.force_valid,
                               o_res.force_valid); errors++; end
                    if (o_res.duty_ratio !== e.duty_ratio) begin
                        $error("duty_ratio exp %0d got %0d", e.duty_ratio,
                               o_res.duty_ratio); errors++; end
                    if (o_res.box_min_x !== e.box_min_x) begin
                        $error("box_min_x exp %0d got %0d", e.box_min_x,
                               o_res.box_min_x); errors++; end
                    if (o_res.box_min_y !== e.box_min_y) begin
                        $error("box_min_y exp %0d got %0d", e.box_min_y,
                               o_res.box_min_y); errors++; end
                    if (o_res.box_max_x !== e.box_max_x) begin
                        $error("box_max_x exp %0d got %0d", e.box_max_x,
                               o_res.box_max_x); errors++; end
                    if (o_res.box_max_y !== e.box_max_y) begin
                        $error("box_max_y exp %0d got %0d", e.box_max_y,
                               o_res.box_max_y); errors++; end
                    if (o_res.box_valid !== e.box_valid) begin
                        $error("box_valid exp %0d got %0d", e.box_valid,
                               o_res.box_valid); errors++; end
                end
            end
            i_pop <= !hold_off && (calm || $urandom_range(0, 99) >= 13);
        end
    end

    // Long receiver stall so results back up and the input stalls, then a calm run.
    initial begin
        wait (i_rst_n);
        repeat (300) @(posedge i_clk);
        hold_off = 1;
        repeat (1500) @(posedge i_clk);
        hold_off = 0;
        repeat (2000) @(posedge i_clk);
        calm = 1;
        repeat (3000) @(posedge i_clk);
        calm = 0;
    end

    initial begin
        int idle;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle = 0;
        while (!(stim_done && !i_push && summary_queue.size() == 0)) begin
            @(posedge i_clk);
            if ((i_push && !o_full) || (i_pop && !o_empty)) idle = 0;
            else idle++;
            if (idle >= WATCHDOG_LIMIT) begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
        repeat (200) @(posedge i_clk);
        if (summary_queue.size() != 0) errors++;
        $display("Sent %0d pen samples; checked %0d trace summaries.",
                 samples_sent, summaries_seen);
        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule

### files.f
hdl/cts_pkg.sv
hdl/cts_front.sv
hdl/cts_back.sv
hdl/contact_trace_statistics_core.sv
test/tb_top.sv
